// ===== rtl/core/bmft_pkg.sv =====
// bmft_pkg: shared constants, opcodes and beat types for the flash translation block
// no dependencies; used by bmft_front, bmft_back and the top level
package bmft_pkg;

    // geometry
    localparam int PAGES_PER_BLK = 16;
    localparam int DATA_BLOCKS   = 64;
    localparam int TOTAL_BLOCKS  = DATA_BLOCKS + 1;

    // internal widths
    localparam int OFF_W = (PAGES_PER_BLK > 1) ? $clog2(PAGES_PER_BLK) : 1;
    localparam int LBN_W = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
    localparam int BLK_W = $clog2(TOTAL_BLOCKS);

    // field widths of the beats
    localparam int LSN_W  = 10;
    localparam int TAG_W  = 4;
    localparam int OP_W   = 2;
    localparam int PAGE_W = 11;
    localparam int EBLK_W = 7;

    // request kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // command opcodes
    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_PROGRAM = 2'd1;
    localparam logic [OP_W-1:0] OP_COPY    = 2'd2;
    localparam logic [OP_W-1:0] OP_ERASE   = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [LSN_W-1:0] logical_sector;
        logic [TAG_W-1:0] buffer_tag;
    } req_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] dest_page;
        logic [PAGE_W-1:0] src_page;
        logic [EBLK_W-1:0] erase_block;
        logic [TAG_W-1:0]  tag_out;
        logic              last;
    } cmd_t;

    // decoded request as it sits in the queue
    typedef struct packed {
        logic             kind;
        logic [LBN_W-1:0] lbn;
        logic [OFF_W-1:0] off;
        logic [TAG_W-1:0] tag;
    } item_t;

endpackage

// ===== rtl/core/block_mapped_flash_translation_top.sv =====
// block_mapped_flash_translation_top: host sector requests in, flash command beats out
// depends on bmft_pkg, bmft_front, bmft_back
// path: a request passes the front queue and the back-end IDLE, MAP and ROW states
// beats: one per read or first-time program, PAGES_PER_BLK copy/program beats plus an erase per rewrite,
// from the back-end sequencer, one beat per cycle through one output register unless cmd_stall holds
// reset: map and written marks come up via per-entry and per-row valid flops, no sweep
module block_mapped_flash_translation_top
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bmft_pkg::req_t req,
    output logic           cmd_valid,
    input  logic           cmd_stall,
    output bmft_pkg::cmd_t cmd
);

    // queue link between front and back
    logic            q_valid;
    logic            q_pop;
    bmft_pkg::item_t q_item;

    // front: takes request beats, splits the sector, queues up to two requests
    bmft_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    // back: map lookup, mark lookup, then one beat per cycle for a rewrite while cmd_stall is low
    bmft_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    // erase always closes a request
    a_erase_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.op == bmft_pkg::OP_ERASE) |-> cmd.last)
        else $error("erase beat without last");

    // a copy never targets its own source page
    a_copy_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.op == bmft_pkg::OP_COPY) |-> (cmd.src_page != cmd.dest_page))
        else $error("copy beat with same source and destination");

    // a read is a single-beat request
    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.op == bmft_pkg::OP_READ) |-> cmd.last)
        else $error("read beat without last");

    // back end only pulls from a non-empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// ===== rtl/core/bmft_front.sv =====
// bmft_front: request intake, sector decode and two-entry request queue
// depends on bmft_pkg
module bmft_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bmft_pkg::req_t  req,
    output logic            q_valid,
    input  logic            q_pop,
    output bmft_pkg::item_t q_item
);

    bmft_pkg::item_t q_mem [2];
    bmft_pkg::item_t dec;
    logic [bmft_pkg::LSN_W-1:0] blk_num;
    logic       push;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // split sector into logical block and page offset
    assign blk_num   = bmft_pkg::LSN_W'(32'(req.logical_sector) / bmft_pkg::PAGES_PER_BLK);
    assign dec.kind  = req.kind;
    assign dec.lbn   = bmft_pkg::LBN_W'(32'(blk_num) % bmft_pkg::DATA_BLOCKS);
    assign dec.off   = bmft_pkg::OFF_W'(32'(req.logical_sector) % bmft_pkg::PAGES_PER_BLK);
    assign dec.tag   = req.buffer_tag;

    assign req_stall = (count_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== rtl/core/bmft_back.sv =====
// bmft_back: block map, written marks and command sequencer with output register
// depends on bmft_pkg
module bmft_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  bmft_pkg::item_t q_item,
    output logic            cmd_valid,
    input  logic            cmd_stall,
    output bmft_pkg::cmd_t  cmd
);

    localparam int P     = bmft_pkg::PAGES_PER_BLK;
    localparam int NB    = bmft_pkg::TOTAL_BLOCKS;
    localparam int ND    = bmft_pkg::DATA_BLOCKS;
    localparam int BLK_W = bmft_pkg::BLK_W;
    localparam int PW    = bmft_pkg::PAGE_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAP   = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_PAGES = 3'd3;
    localparam logic [2:0] ST_ERASE = 3'd4;

    // memories: map entries and one row of written marks per physical block
    logic [BLK_W-1:0] map_mem [ND];
    logic [P-1:0]     row_mem [NB];

    logic [2:0]             state_reg, state_next;
    logic [bmft_pkg::OFF_W-1:0] idx_reg, idx_next;
    logic [ND-1:0]          map_valid_reg, map_valid_next;
    logic [NB-1:0]          row_valid_reg, row_valid_next;
    logic [BLK_W-1:0]       spare_reg, spare_next;
    logic                   cmd_valid_reg, cmd_valid_next;
    bmft_pkg::cmd_t         cmd_reg, cmd_next;

    bmft_pkg::item_t cur_reg;
    logic [BLK_W-1:0] map_rd_reg;
    logic [P-1:0]     row_rd_reg;
    logic [BLK_W-1:0] old_reg;
    logic [PW-1:0]    old_base_reg;
    logic [PW-1:0]    spare_base_reg;

    logic [BLK_W-1:0] map_word;
    logic [P-1:0]     row_word;
    logic [P-1:0]     off_mask;
    logic             hit;
    logic             can_load;
    logic             load;
    logic             row_wr_en;
    logic [BLK_W-1:0] row_wr_addr;
    logic             rewrite_en;

    // unwritten map entries read as identity, unwritten rows as all clear
    assign map_word = map_valid_reg[cur_reg.lbn] ? map_rd_reg : BLK_W'(cur_reg.lbn);
    assign row_word = row_valid_reg[old_reg] ? row_rd_reg : '0;
    assign off_mask = {{(P-1){1'b0}}, 1'b1} << cur_reg.off;
    assign hit      = row_word[cur_reg.off];
    assign can_load = !cmd_valid_reg || !cmd_stall;

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        spare_next  = spare_reg;
        q_pop       = 1'b0;
        load        = 1'b0;
        row_wr_en   = 1'b0;
        row_wr_addr = old_reg;
        rewrite_en  = 1'b0;
        cmd_next    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                if (cur_reg.kind == bmft_pkg::KIND_READ)
                begin
                    if (can_load)
                    begin
                        load               = 1'b1;
                        cmd_next.op        = bmft_pkg::OP_READ;
                        cmd_next.dest_page = old_base_reg + PW'(cur_reg.off);
                        cmd_next.tag_out   = cur_reg.tag;
                        cmd_next.last      = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
                else if (!hit)
                begin
                    if (can_load)
                    begin
                        load               = 1'b1;
                        row_wr_en          = 1'b1;
                        cmd_next.op        = bmft_pkg::OP_PROGRAM;
                        cmd_next.dest_page = old_base_reg + PW'(cur_reg.off);
                        cmd_next.tag_out   = cur_reg.tag;
                        cmd_next.last      = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
                else
                begin
                    // rebuild in the spare: marks move over, map and spare swap now
                    row_wr_en   = 1'b1;
                    row_wr_addr = spare_reg;
                    rewrite_en  = 1'b1;
                    spare_next  = old_reg;
                    idx_next    = '0;
                    state_next  = ST_PAGES;
                end
            end
            ST_PAGES:
            begin
                if (can_load)
                begin
                    load               = 1'b1;
                    cmd_next.dest_page = spare_base_reg + PW'(idx_reg);
                    if (idx_reg == cur_reg.off)
                    begin
                        cmd_next.op      = bmft_pkg::OP_PROGRAM;
                        cmd_next.tag_out = cur_reg.tag;
                    end
                    else
                    begin
                        cmd_next.op       = bmft_pkg::OP_COPY;
                        cmd_next.src_page = old_base_reg + PW'(idx_reg);
                    end
                    if (idx_reg == bmft_pkg::OFF_W'(P - 1))
                    begin
                        state_next = ST_ERASE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_ERASE:
            begin
                if (can_load)
                begin
                    load                 = 1'b1;
                    cmd_next.op          = bmft_pkg::OP_ERASE;
                    cmd_next.erase_block = bmft_pkg::EBLK_W'(old_reg);
                    cmd_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        map_valid_next = map_valid_reg;
        row_valid_next = row_valid_reg;
        if (row_wr_en)
        begin
            row_valid_next[row_wr_addr] = 1'b1;
        end
        if (rewrite_en)
        begin
            row_valid_next[old_reg]     = 1'b0;
            map_valid_next[cur_reg.lbn] = 1'b1;
        end
        if (load)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            map_valid_reg <= '0;
            row_valid_reg <= '0;
            spare_reg     <= BLK_W'(ND);
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            map_valid_reg <= map_valid_next;
            row_valid_reg <= row_valid_next;
            spare_reg     <= spare_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_next;
        end
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == ST_MAP)
        begin
            old_reg        <= map_word;
            old_base_reg   <= PW'(32'(map_word) * P);
            spare_base_reg <= PW'(32'(spare_reg) * P);
        end
    end

    // map memory, registered read
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            map_rd_reg <= map_mem[q_item.lbn];
        end
        if (rewrite_en)
        begin
            map_mem[cur_reg.lbn] <= spare_reg;
        end
    end

    // written-mark rows, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MAP)
        begin
            row_rd_reg <= row_mem[map_word];
        end
        if (row_wr_en)
        begin
            row_mem[row_wr_addr] <= row_word | off_mask;
        end
    end

endmodule
